### hw/rtl/isfs_pkg.sv
// Shared constants, action codes and register codes for the flux summation block.
package isfs_pkg;
  localparam int MAX_SOURCES_DEF = 1024;
  localparam int POS_BITS_DEF    = 24;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] REG_LOW_GAIN  = 2'd0;
  localparam logic [1:0] REG_MID_GAIN  = 2'd1;
  localparam logic [1:0] REG_LOW_LIMIT = 2'd2;
  localparam logic [1:0] REG_UP_LIMIT  = 2'd3;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int SUM_BITS      = 64;
  localparam int TOTAL_BITS    = 11;
endpackage

### hw/rtl/isfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module isfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### hw/rtl/isfs_div.sv
// Radix-2 restoring divider: 64-bit numerator over DEN_BITS-bit denominator, one bit a cycle.
module isfs_div #(
  parameter int DEN_BITS = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [63:0]         quo
);
  localparam int REM_BITS = DEN_BITS + 1;

  logic [REM_BITS-1:0] rem;
  logic [DEN_BITS-1:0] dreg;
  logic [63:0]         nsh;
  logic [6:0]          cnt;
  logic                busy;
  logic [REM_BITS-1:0] trial;
  logic [REM_BITS:0]   diff;

  always_comb begin
    trial = {rem[REM_BITS-2:0], nsh[63]};
    diff  = {1'b0, trial} - {2'b00, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        rem  <= '0;
        dreg <= den;
        nsh  <= num;
        quo  <= '0;
      end else if (busy) begin
        if (!diff[REM_BITS]) begin
          rem <= diff[REM_BITS-1:0];
        end else begin
          rem <= trial;
        end
        quo <= {quo[62:0], ~diff[REM_BITS]};
        nsh <= {nsh[62:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hw/rtl/inverse_square_flux_summation.sv
// Top level of the inverse-square flux summation block.
// Words are clear, append or query. Clear and append go from acceptance
// straight to the output state. A query visits each stored source in turn:
// a RAM read, three squares for the squared distance and one product for
// gain times weight on one shared 32x32 multiplier, then a 64-step
// bit-serial divide. One word is in work at a time; in_stall is high from
// acceptance until the result word leaves the output register. The source
// store is one RAM holding a packed entry per source, addressed by entry
// number; only entries below the fill count are read, so no clearing pass
// exists.
module inverse_square_flux_summation #(
  parameter int MAX_SOURCES = isfs_pkg::MAX_SOURCES_DEF,
  parameter int POS_BITS    = isfs_pkg::POS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [isfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [isfs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [31:0]                         particle_id,
  input  logic signed [POS_BITS-1:0]          pos_x,
  input  logic signed [POS_BITS-1:0]          pos_y,
  input  logic signed [POS_BITS-1:0]          pos_z,
  input  logic [31:0]                         weight,
  input  logic [15:0]                         metallicity,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [isfs_pkg::SUM_BITS-1:0]       low_metal_sum,
  output logic [isfs_pkg::SUM_BITS-1:0]       mid_metal_sum,
  output logic                                zero_distance,
  output logic                                store_full,
  output logic [isfs_pkg::TOTAL_BITS-1:0]     source_total
);
  localparam int AW     = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW     = $clog2(MAX_SOURCES + 1);
  localparam int DB     = POS_BITS + 1;       // abs difference width
  localparam int SQ     = 2 * DB;             // one square
  localparam int R2B    = SQ + 2;             // sum of three squares
  localparam int EW     = 32 + 3 * POS_BITS + 32 + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_CHK, S_DX, S_DY, S_DZ, S_NUM, S_DIV, S_ACC, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [31:0] low_gain, mid_gain;
  logic [15:0] low_limit, up_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_gain  <= 32'd15;
      mid_gain  <= 32'd3;
      low_limit <= 16'd8;
      up_limit  <= 16'd819;
    end else if (cfg_we) begin
      case (cfg_index)
        isfs_pkg::REG_LOW_GAIN:  low_gain  <= cfg_data;
        isfs_pkg::REG_MID_GAIN:  mid_gain  <= cfg_data;
        isfs_pkg::REG_LOW_LIMIT: low_limit <= cfg_data[15:0];
        isfs_pkg::REG_UP_LIMIT:  up_limit  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // latched word
  logic [31:0]                id_r;
  logic signed [POS_BITS-1:0] px_r, py_r, pz_r;
  logic [CW-1:0]              count;
  logic [CW-1:0]              k;
  logic [R2B-1:0]             r2;
  logic                       is_low;
  logic [63:0]                lsum, msum;
  logic                       zflag, full_r;

  // source store: one packed RAM entry per source
  logic          we;
  logic [EW-1:0] wdata, rdata;
  logic [AW-1:0] waddr, raddr;

  assign we    = (state == S_IDLE) && in_valid && (action == isfs_pkg::ACT_APPEND) &&
                 (count < CW'(MAX_SOURCES));
  assign waddr = count[AW-1:0];
  assign wdata = {particle_id, pos_x, pos_y, pos_z, weight, metallicity};
  assign raddr = k[AW-1:0];

  isfs_ram #(.WIDTH(EW), .DEPTH(MAX_SOURCES)) u_store (
    .clk(clk), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
    .rd_addr(raddr), .rd_data(rdata)
  );

  logic [31:0]                s_id, s_w;
  logic signed [POS_BITS-1:0] s_x, s_y, s_z;
  logic [15:0]                s_met;
  assign {s_id, s_x, s_y, s_z, s_w, s_met} = rdata;

  // shared multiplier, one product per cycle
  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [63:0]    prod;
  logic signed [DB-1:0] dif;
  logic [DB-1:0]  adif;

  always_comb begin
    case (state)
      S_DX:    dif = DB'(px_r) - DB'(s_x);
      S_DY:    dif = DB'(py_r) - DB'(s_y);
      default: dif = DB'(pz_r) - DB'(s_z);
    endcase
    adif  = dif[DB-1] ? DB'(-dif) : DB'(dif);
    if (state == S_NUM) begin
      mul_a = is_low ? low_gain : mid_gain;
      mul_b = s_w;
    end else begin
      mul_a = 32'(adif);
      mul_b = 32'(adif);
    end
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // divider takes gain times weight straight off the multiplier
  logic        div_start, div_done;
  logic [63:0] quo;
  isfs_div #(.DEN_BITS(R2B)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod), .den(r2),
    .done(div_done), .quo(quo)
  );
  assign div_start = (state == S_NUM) && (r2 != '0);

  logic [63:0] term;
  logic [64:0] add;
  assign term = (r2 == '0) ? '1 : quo;
  assign add  = is_low ? ({1'b0, lsum} + {1'b0, term}) : ({1'b0, msum} + {1'b0, term});

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            id_r   <= particle_id;
            px_r   <= pos_x;
            py_r   <= pos_y;
            pz_r   <= pos_z;
            lsum   <= '0;
            msum   <= '0;
            zflag  <= 1'b0;
            full_r <= 1'b0;
            k      <= '0;
            state  <= S_OUT;
            case (action)
              isfs_pkg::ACT_CLEAR: count <= '0;
              isfs_pkg::ACT_APPEND: begin
                if (count < CW'(MAX_SOURCES)) begin
                  count <= count + CW'(1);
                end else begin
                  full_r <= 1'b1;
                end
              end
              isfs_pkg::ACT_QUERY: state <= S_RD;
              default: ;
            endcase
          end
        end
        S_RD: begin
          state <= (k < count) ? S_WAIT : S_OUT;
        end
        S_WAIT: state <= S_CHK;
        S_CHK: begin
          if (s_id == 32'd0 || s_id == id_r || s_met >= low_limit && s_met >= up_limit) begin
            k     <= k + CW'(1);
            state <= S_RD;
          end else begin
            is_low <= (s_met < low_limit);
            state  <= S_DX;
          end
        end
        S_DX: begin
          r2    <= R2B'(prod);
          state <= S_DY;
        end
        S_DY: begin
          r2    <= r2 + R2B'(prod);
          state <= S_DZ;
        end
        S_DZ: begin
          r2    <= r2 + R2B'(prod);
          state <= S_NUM;
        end
        S_NUM: begin
          state <= (r2 == '0) ? S_ACC : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (r2 == '0) begin
            zflag <= 1'b1;
          end
          if (is_low) begin
            lsum <= add[64] ? '1 : add[63:0];
          end else begin
            msum <= add[64] ? '1 : add[63:0];
          end
          k     <= k + CW'(1);
          state <= S_RD;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid     <= 1'b1;
            low_metal_sum <= lsum;
            mid_metal_sum <= msum;
            zero_distance <= zflag;
            store_full    <= full_r;
            source_total  <= isfs_pkg::TOTAL_BITS'(count);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // appends never push the fill count past the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SOURCES)) else $error("fill count overflow");
  // a result word is only shown from the output state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  // the divider finishes only while a query waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("stray divider completion");
endmodule
